[hdl/hid_keyboard_report_key_events_defines.svh]
// assertion macros for the keyboard report event block
`ifndef HID_KEYBOARD_REPORT_KEY_EVENTS_DEFINES_SVH
`define HID_KEYBOARD_REPORT_KEY_EVENTS_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication check
`define HKRE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hkre same-cycle check failed");
// next-cycle implication check
`define HKRE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hkre next-cycle check failed");
`else
`define HKRE_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define HKRE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[hdl/hkre_pkg.sv]
// shared constants and types for the keyboard report event block
package hkre_pkg;

   // key map geometry
   localparam int KEY_SLOTS        = 6;
   localparam int KEY_CODES        = 256;
   localparam int KEY_W            = $clog2(KEY_CODES);
   localparam int SLOT_W           = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int SCAN_LEN         = KEY_CODES + KEY_SLOTS;
   localparam int IDX_W            = $clog2(SCAN_LEN + 1);

   // report format
   localparam int REPORT_FIELDS    = 7;
   localparam int MIN_REPORT_BYTES = 8;
   localparam int BCOUNT_W         = 7;
   localparam int REQ_DATA_W       = 64;

   // result limits
   localparam int MAX_RESULTS      = 12;
   localparam int CNT_W            = $clog2(MAX_RESULTS + 1);

   // hold timer
   localparam int DELAY_W          = 16;

   typedef enum logic [1:0] {
      EVT_CLICK = 2'd0,
      EVT_DOWN  = 2'd1,
      EVT_HOLD  = 2'd2
   } evt_kind_type;

   // event handed from the sequencer to the output stage
   typedef struct packed {
      logic             valid;
      evt_kind_type     kind;
      logic [KEY_W-1:0] code;
   } evt_push_type;

   // output stage status back to the sequencer
   typedef struct packed {
      logic push_ready;
      logic pend_valid;
   } evt_stat_type;

endpackage

[hdl/hkre_key_ram.sv]
// simple dual-port ram with registered read data for the pressed-key map
module hkre_key_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/hkre_evt_out.sv]
// pending event stage and output register that marks the final beat of an item
module hkre_evt_out
   import hkre_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  evt_push_type push,
   input  logic         flush,
   output evt_stat_type stat,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // key_code
   output logic [1:0]   rsp_tuser,   // event_kind
   output logic         rsp_tlast    // last
);

   logic             pend_valid_ff, pend_valid_in;
   evt_kind_type     pend_kind_ff, pend_kind_in;
   logic [KEY_W-1:0] pend_code_ff, pend_code_in;
   logic             out_valid_ff, out_valid_in;
   evt_kind_type     out_kind_ff, out_kind_in;
   logic [KEY_W-1:0] out_code_ff, out_code_in;
   logic             out_last_ff, out_last_in;
   logic             out_free;
   logic             move;

   // pending event moves on once a newer one arrives or the item ends
   always_comb begin
      out_free      = !out_valid_ff || rsp_tready;
      move          = pend_valid_ff && out_free && (push.valid || flush);
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_code_in  = pend_code_ff;
      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_code_in   = out_code_ff;
      out_last_in   = out_last_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_kind_in  = pend_kind_ff;
         out_code_in  = pend_code_ff;
         out_last_in  = !push.valid;
         pend_valid_in = 1'b0;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (push.valid) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = push.kind;
         pend_code_in  = push.code;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      pend_code_ff <= pend_code_in;
      out_kind_ff  <= out_kind_in;
      out_code_ff  <= out_code_in;
      out_last_ff  <= out_last_in;
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // status and result beat
   assign stat.push_ready = !pend_valid_ff || out_free;
   assign stat.pend_valid = pend_valid_ff;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = 8'(out_code_ff);
   assign rsp_tuser       = out_kind_ff;
   assign rsp_tlast       = out_last_ff;

endmodule

[hdl/hid_keyboard_report_key_events.sv]
// After reset the key map is cleared one entry a cycle; no beat is taken meanwhile.
// A report sweeps the pressed-key memory one entry a cycle while results are not stalled
// (256 codes, then 6 slots), then a flush.
// A tick advances the hold timer; once the delay runs out it checks the held key for a hold event.
// Results leave through a pending stage and an output register; rsp backpressure stalls.
// Reset clears the map, the hold tracker and the delay.
`include "hid_keyboard_report_key_events_defines.svh"
module hid_keyboard_report_key_events
   import hkre_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // transfer_ok, byte_count, report_byte_0..6
   input  logic [0:0]            req_tuser,  // op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,  // key_code
   output logic [1:0]            rsp_tuser,  // event_kind
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [DELAY_W-1:0]    csr_wr_data  // hold delay in ticks
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      PH_CLICK,
      PH_DOWN,
      PH_HOLD
   } phase_type;

   state_type        state_ff, state_in;
   logic [KEY_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             job_tick_ff, job_tick_in;
   logic [KEY_W-1:0] job_code_ff, job_code_in;
   logic [KEY_W-1:0] codes_ff [KEY_SLOTS];
   logic [KEY_W-1:0] codes_in [KEY_SLOTS];
   logic             ev_valid_ff, ev_valid_in;
   phase_type        ev_phase_ff, ev_phase_in;
   logic [KEY_W-1:0] ev_addr_ff, ev_addr_in;
   logic [SLOT_W-1:0] ev_slot_ff, ev_slot_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             hold_active_ff, hold_active_in;
   logic [KEY_W-1:0] held_key_ff, held_key_in;
   logic [DELAY_W-1:0] hold_elapsed_ff, hold_elapsed_in;
   logic [DELAY_W-1:0] dly_ticks_ff, dly_ticks_in;

   logic              req_op;
   logic              req_ok;
   logic [BCOUNT_W-1:0] req_count;
   logic [7:0]        req_byte [REPORT_FIELDS];
   logic [KEY_W-1:0]  slot_code [KEY_SLOTS];
   logic              req_start;

   logic [IDX_W-1:0]  issue_limit;
   logic              issue_left;
   logic [IDX_W-1:0]  slot_full;
   logic [SLOT_W-1:0] iss_slot;
   logic [KEY_W-1:0]  iss_addr;
   phase_type         iss_phase;

   logic              found;
   logic              dup;
   logic              fire;
   logic              reported;
   logic              adv;
   logic [DELAY_W-1:0] el_new;

   logic              wr_en;
   logic [KEY_W-1:0]  wr_addr;
   logic [0:0]        wr_data;
   logic              rd_en;
   logic [0:0]        rd_data;

   evt_push_type      push;
   evt_stat_type      evt_stat;
   logic              flush;

   // unpack the request beat
   always_comb begin
      req_op    = req_tuser[0];
      req_ok    = req_tdata[0];
      req_count = req_tdata[BCOUNT_W:1];
      for (int f = 0; f < REPORT_FIELDS; f++) begin
         req_byte[f] = req_tdata[8 + 8*f +: 8];
      end
      req_start = (req_count > BCOUNT_W'(MIN_REPORT_BYTES));
   end

   // key slot codes, taken from report byte 1 on when the byte count exceeds the minimum, else from byte 0
   always_comb begin
      for (int j = 0; j < KEY_SLOTS; j++) begin
         slot_code[j] = '0;
         for (int f = 0; f < REPORT_FIELDS; f++) begin
            if (f == j + int'(req_start) && ({1'b0, req_byte[f]} < 9'(KEY_CODES))) begin
               slot_code[j] = req_byte[f][KEY_W-1:0];
            end
         end
      end
   end

   // address stream: every code for release checks, then the slots; a tick job reads only the held key
   always_comb begin
      issue_limit = job_tick_ff ? IDX_W'(1) : IDX_W'(SCAN_LEN);
      issue_left  = (idx_ff < issue_limit);
      slot_full   = idx_ff - IDX_W'(KEY_CODES);
      iss_slot    = slot_full[SLOT_W-1:0];
      if (job_tick_ff) begin
         iss_addr  = job_code_ff;
         iss_phase = PH_HOLD;
      end else if (idx_ff < IDX_W'(KEY_CODES)) begin
         iss_addr  = idx_ff[KEY_W-1:0];
         iss_phase = PH_CLICK;
      end else begin
         iss_addr  = codes_ff[iss_slot];
         iss_phase = PH_DOWN;
      end
   end

   // evaluate the entry whose map bit has come back
   always_comb begin
      found = 1'b0;
      dup   = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
         if (codes_ff[j] != '0 && codes_ff[j] == ev_addr_ff) begin
            found = 1'b1;
         end
         if (SLOT_W'(j) < ev_slot_ff && codes_ff[j] == ev_addr_ff) begin
            dup = 1'b1;
         end
      end
      fire      = 1'b0;
      wr_data   = 1'b0;
      push.kind = EVT_CLICK;
      case (ev_phase_ff)
         PH_CLICK: begin
            fire      = rd_data[0] && !found;
            push.kind = EVT_CLICK;
         end
         PH_DOWN: begin
            fire      = (ev_addr_ff != '0) && !(rd_data[0] || dup);
            // the clearing pass always writes zeros
            wr_data   = (state_ff != ST_CLEAR);
            push.kind = EVT_DOWN;
         end
         PH_HOLD: begin
            fire      = (ev_addr_ff != '0) && rd_data[0];
            push.kind = EVT_HOLD;
         end
         default: begin
            fire = 1'b0;
         end
      endcase
      reported   = ev_valid_ff && fire && (cnt_ff < CNT_W'(MAX_RESULTS));
      adv        = !ev_valid_ff || !reported || evt_stat.push_ready;
      push.valid = (state_ff == ST_SCAN) && reported && adv;
      push.code  = ev_addr_ff;
   end

   // sequencer and hold tracker
   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      idx_in          = idx_ff;
      job_tick_in     = job_tick_ff;
      job_code_in     = job_code_ff;
      codes_in        = codes_ff;
      ev_valid_in     = ev_valid_ff;
      ev_phase_in     = ev_phase_ff;
      ev_addr_in      = ev_addr_ff;
      ev_slot_in      = ev_slot_ff;
      cnt_in          = cnt_ff;
      hold_active_in  = hold_active_ff;
      held_key_in     = held_key_ff;
      hold_elapsed_in = hold_elapsed_ff;
      dly_ticks_in    = csr_wr_en ? csr_wr_data : dly_ticks_ff;
      wr_en           = 1'b0;
      wr_addr         = ev_addr_ff;
      rd_en           = 1'b0;
      flush           = 1'b0;
      el_new          = (hold_elapsed_ff == '1) ? hold_elapsed_ff
                                                : hold_elapsed_ff + DELAY_W'(1);
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + KEY_W'(1);
            if (clr_ff == KEY_W'(KEY_CODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               idx_in      = '0;
               cnt_in      = '0;
               ev_valid_in = 1'b0;
               if (req_op) begin
                  // tick: advance the hold timer
                  if (hold_active_ff && dly_ticks_ff != '0) begin
                     if (el_new >= dly_ticks_ff) begin
                        job_tick_in     = 1'b1;
                        job_code_in     = held_key_ff;
                        hold_active_in  = 1'b0;
                        held_key_in     = '0;
                        hold_elapsed_in = '0;
                        state_in        = ST_SCAN;
                     end else begin
                        hold_elapsed_in = el_new;
                     end
                  end
               end else if (req_ok && req_count >= BCOUNT_W'(MIN_REPORT_BYTES)) begin
                  job_tick_in = 1'b0;
                  codes_in    = slot_code;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (adv) begin
               // apply the evaluated entry
               if (ev_valid_ff && fire) begin
                  wr_en = 1'b1;
                  if (ev_phase_ff == PH_CLICK && hold_active_ff
                      && held_key_ff == ev_addr_ff) begin
                     hold_active_in  = 1'b0;
                     held_key_in     = '0;
                     hold_elapsed_in = '0;
                  end
                  if (ev_phase_ff == PH_DOWN && !hold_active_ff) begin
                     hold_active_in  = 1'b1;
                     held_key_in     = ev_addr_ff;
                     hold_elapsed_in = '0;
                  end
               end
               if (reported) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               // issue the next read
               rd_en       = issue_left;
               ev_valid_in = issue_left;
               ev_phase_in = iss_phase;
               ev_addr_in  = iss_addr;
               ev_slot_in  = iss_slot;
               if (issue_left) begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            if (!ev_valid_ff && !issue_left) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            flush = 1'b1;
            if (!evt_stat.pend_valid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      job_code_ff <= job_code_in;
      codes_ff    <= codes_in;
      ev_phase_ff <= ev_phase_in;
      ev_addr_ff  <= ev_addr_in;
      ev_slot_ff  <= ev_slot_in;
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         idx_ff          <= '0;
         job_tick_ff     <= 1'b0;
         ev_valid_ff     <= 1'b0;
         cnt_ff          <= '0;
         hold_active_ff  <= 1'b0;
         held_key_ff     <= '0;
         hold_elapsed_ff <= '0;
         dly_ticks_ff    <= '0;
      end else begin
         state_ff        <= state_in;
         clr_ff          <= clr_in;
         idx_ff          <= idx_in;
         job_tick_ff     <= job_tick_in;
         ev_valid_ff     <= ev_valid_in;
         cnt_ff          <= cnt_in;
         hold_active_ff  <= hold_active_in;
         held_key_ff     <= held_key_in;
         hold_elapsed_ff <= hold_elapsed_in;
         dly_ticks_ff    <= dly_ticks_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   // pressed-key map
   hkre_key_ram #(
      .ADDR_W (KEY_W),
      .DATA_W (1)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (iss_addr),
      .rd_data (rd_data)
   );

   // result staging
   hkre_evt_out u_evt_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .flush      (flush),
      .stat       (evt_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // checks
   `HKRE_ASSERT_SAME(a_cnt_cap, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_RESULTS))
   `HKRE_ASSERT_NEXT(a_stall_holds, clock, reset, state_ff == ST_SCAN && ev_valid_ff && !adv, $stable(rd_data) && $stable(ev_addr_ff))
   `HKRE_ASSERT_SAME(a_held_key_nonzero, clock, reset, hold_active_ff, held_key_ff != '0)
   `HKRE_ASSERT_SAME(a_idle_drained, clock, reset, state_ff == ST_IDLE, !ev_valid_ff && !evt_stat.pend_valid)

endmodule
